>>> sv/qpr_pkg.sv
// shared types, widths and operation codes for the quaternion product and rotate unit
package qpr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int OP_W    = 2;
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int SUM_W   = PROD_W + 2;
  localparam int COEF_W  = SUM_W - FRAC_BITS + 1;
  localparam int DOT_W   = COEF_W + DATA_WIDTH;
  localparam int EXACT_W = DOT_W + 3;
  localparam int ROUND_W = EXACT_W - FRAC_BITS;

  localparam int IN_BITS    = OP_W + 11 * DATA_WIDTH;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8;

  localparam logic signed [SUM_W-1:0] ONE_EXACT = SUM_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF_SUM  = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [EXACT_W-1:0] HALF_EXACT = EXACT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ROUND_W-1:0] RES_MAX = ROUND_W'((64'(1) << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ROUND_W-1:0] RES_MIN = -RES_MAX - ROUND_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_PRODUCT = 2'd0,
    OP_ROTATE  = 2'd1,
    OP_CONJ    = 2'd2
  } op_e;

  typedef logic [3:0][DATA_WIDTH-1:0] quat_t;
  typedef logic [2:0][DATA_WIDTH-1:0] vec_t;

  typedef struct packed {
    op_e                         op;
    quat_t                       qa;
    vec_t                        vec;
    logic [3:0][SUM_W-1:0]       prod_sum;
    logic [8:0][COEF_W-1:0]      coef;
  } front_t;

  typedef struct packed {
    logic [3:0][EXACT_W-1:0]     exact;
  } back_t;

endpackage

>>> sv/qpr_front.sv
// stages one and two: shared multiplier array, product sums and rotation matrix coefficients
module qpr_front import qpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  op_e    op_i,
  input  quat_t  qa_i,
  input  quat_t  qb_i,
  input  vec_t   vec_i,
  output logic   valid_o,
  input  logic   ready_i,
  output front_t data_o
);

  logic                     v1_q, v2_q;
  logic                     ready1, ready2;
  op_e                      op1_q;
  quat_t                    qa1_q;
  vec_t                     vec1_q;
  logic signed [PROD_W-1:0] prod_d [16];
  logic signed [PROD_W-1:0] prod_q [16];
  quat_t                    mb;
  logic signed [SUM_W-1:0]  p [16];
  logic signed [SUM_W-1:0]  c [9];
  front_t                   s2_d, s2_q;

  assign ready2  = !v2_q || ready_i;
  assign ready1  = !v1_q || ready2;
  assign ready_o = ready1;

  // rotation reuses the array with a times a
  always_comb begin
    mb = (op_i == OP_ROTATE) ? qa_i : qb_i;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[i*4+j] = $signed(qa_i[i]) * $signed(mb[j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      p[k] = SUM_W'(prod_q[k]);
    end
    s2_d.op  = op1_q;
    s2_d.qa  = qa1_q;
    s2_d.vec = vec1_q;
    s2_d.prod_sum[0] = p[0] - p[5] - p[10] - p[15];
    s2_d.prod_sum[1] = p[1] + p[4] - p[11] + p[14];
    s2_d.prod_sum[2] = p[2] + p[7] + p[8] - p[13];
    s2_d.prod_sum[3] = p[3] - p[6] + p[9] + p[12];
    c[0] = ONE_EXACT - (p[10] <<< 1) - (p[15] <<< 1);
    c[1] = (p[6] + p[3]) <<< 1;
    c[2] = (p[7] - p[2]) <<< 1;
    c[3] = (p[6] - p[3]) <<< 1;
    c[4] = ONE_EXACT - (p[5] <<< 1) - (p[15] <<< 1);
    c[5] = (p[11] + p[1]) <<< 1;
    c[6] = (p[7] + p[2]) <<< 1;
    c[7] = (p[11] - p[1]) <<< 1;
    c[8] = ONE_EXACT - (p[5] <<< 1) - (p[10] <<< 1);
    for (int k = 0; k < 9; k++) begin
      s2_d.coef[k] = COEF_W'((c[k] + HALF_SUM) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= valid_i;
      if (ready2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && valid_i) begin
      op1_q  <= op_i;
      qa1_q  <= qa_i;
      vec1_q <= vec_i;
      for (int k = 0; k < 16; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
    if (ready2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = s2_q;

endmodule

>>> sv/qpr_back.sv
// stages three and four: coefficient times vector products and per-operation exact sums
module qpr_back import qpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  front_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output back_t  data_o
);

  logic                      v3_q, v4_q;
  logic                      ready3, ready4;
  op_e                       op3_q;
  quat_t                     qa3_q;
  logic [3:0][SUM_W-1:0]     sum3_q;
  logic signed [DOT_W-1:0]   dot_d [9];
  logic signed [DOT_W-1:0]   dot_q [9];
  logic signed [EXACT_W-1:0] d [9];
  logic signed [EXACT_W-1:0] neg [4];
  back_t                     s4_d, s4_q;

  assign ready4  = !v4_q || ready_i;
  assign ready3  = !v3_q || ready4;
  assign ready_o = ready3;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        dot_d[r*3+j] = $signed(data_i.coef[r*3+j]) * $signed(data_i.vec[j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      d[k] = EXACT_W'(dot_q[k]);
    end
    for (int k = 0; k < 4; k++) begin
      neg[k] = -EXACT_W'($signed(qa3_q[k]));
    end
    s4_d.exact = '0;
    case (op3_q)
      OP_PRODUCT: begin
        for (int k = 0; k < 4; k++) begin
          s4_d.exact[k] = EXACT_W'($signed(sum3_q[k]));
        end
      end
      OP_ROTATE: begin
        s4_d.exact[1] = d[0] + d[1] + d[2];
        s4_d.exact[2] = d[3] + d[4] + d[5];
        s4_d.exact[3] = d[6] + d[7] + d[8];
      end
      OP_CONJ: begin
        s4_d.exact[0] = EXACT_W'($signed(qa3_q[0])) <<< FRAC_BITS;
        s4_d.exact[1] = neg[1] <<< FRAC_BITS;
        s4_d.exact[2] = neg[2] <<< FRAC_BITS;
        s4_d.exact[3] = neg[3] <<< FRAC_BITS;
      end
      default: s4_d.exact = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ready3) v3_q <= valid_i;
      if (ready4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && valid_i) begin
      op3_q  <= data_i.op;
      qa3_q  <= data_i.qa;
      sum3_q <= data_i.prod_sum;
      for (int k = 0; k < 9; k++) begin
        dot_q[k] <= dot_d[k];
      end
    end
    if (ready4 && v3_q) begin
      s4_q <= s4_d;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = s4_q;

endmodule

>>> sv/qpr_round.sv
// stage five: round half up, saturate and hold the result for the output port
module qpr_round import qpr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  back_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output quat_t res_o,
  output logic  sat_o
);

  logic                      v5_q;
  logic                      ready5;
  logic signed [EXACT_W-1:0] t [4];
  logic signed [ROUND_W-1:0] rnd [4];
  quat_t                     res_d, res_q;
  logic                      sat_d, sat_q;

  assign ready5  = !v5_q || ready_i;
  assign ready_o = ready5;

  always_comb begin
    sat_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      t[k]   = $signed(data_i.exact[k]) + HALF_EXACT;
      rnd[k] = ROUND_W'(t[k] >>> FRAC_BITS);
      if (rnd[k] > RES_MAX) begin
        res_d[k] = DATA_WIDTH'(RES_MAX);
        sat_d    = 1'b1;
      end else if (rnd[k] < RES_MIN) begin
        res_d[k] = DATA_WIDTH'(RES_MIN);
        sat_d    = 1'b1;
      end else begin
        res_d[k] = DATA_WIDTH'(rnd[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (ready5) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready5 && valid_i) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign valid_o = v5_q;
  assign res_o   = res_q;
  assign sat_o   = sat_q;

endmodule

>>> sv/quaternion_product_rotate_unit_core.sv
// top level of the quaternion product and rotate unit with stream ports
// Five-stage pipeline in signed Q2.14: a transaction is accepted every cycle while the output
// side keeps up. Stage one is a shared array of sixteen 16x16 multipliers (Hamilton product
// terms, or the a-times-a terms for rotation), stage two sums them and rounds the rotation
// matrix coefficients, stage three multiplies coefficients by the vector, stage four forms
// the exact sums per operation and stage five rounds half up and saturates. Every stage has
// its own valid bit and handshake, so bubbles close up and the input keeps flowing while a
// result waits at the output, until the empty stages behind it have filled.
// Operation code three returns zeros with the saturation flag clear.
module quaternion_product_rotate_unit_core import qpr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // operation, qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z, vec_x, vec_y, vec_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // res_w, res_x, res_y, res_z
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // saturated
  output logic                   m_axis_tuser
);

  op_e    op;
  quat_t  qa, qb, res;
  vec_t   vec;
  logic   f_valid, f_ready, b_valid, b_ready;
  front_t f_data;
  back_t  b_data;

  always_comb begin
    op = op_e'(s_axis_tdata[OP_W-1:0]);
    for (int k = 0; k < 4; k++) begin
      qa[k] = s_axis_tdata[OP_W + k*DATA_WIDTH +: DATA_WIDTH];
      qb[k] = s_axis_tdata[OP_W + (k+4)*DATA_WIDTH +: DATA_WIDTH];
    end
    for (int k = 0; k < 3; k++) begin
      vec[k] = s_axis_tdata[OP_W + (k+8)*DATA_WIDTH +: DATA_WIDTH];
    end
  end

  qpr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .op_i    (op),
    .qa_i    (qa),
    .qb_i    (qb),
    .vec_i   (vec),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .data_o  (f_data)
  );

  qpr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_data),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .data_o  (b_data)
  );

  qpr_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid),
    .ready_o (b_ready),
    .data_i  (b_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .sat_o   (m_axis_tuser)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 4; k++) begin
      m_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH] = res[k];
    end
  end

endmodule
